// ===== hw/rtl/u2u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; imported by every module of the block.
package u2u8_pkg;

  localparam int unsigned MaxBytes  = 6;
  localparam int unsigned CountW    = 3;
  localparam int unsigned JobQDepth = 2;

  localparam logic [15:0] Mask1Byte  = 16'hFF80;
  localparam logic [15:0] Mask2Byte  = 16'hF800;
  localparam logic [15:0] MaskSurr   = 16'hFC00;
  localparam logic [15:0] HighSurr   = 16'hD800;
  localparam logic [15:0] LowSurr    = 16'hDC00;
  localparam logic [7:0]  Lead4      = 8'hF0;
  localparam logic [7:0]  Lead3      = 8'hE0;
  localparam logic [7:0]  Lead2      = 8'hC0;
  localparam logic [7:0]  ContByte   = 8'h80;
  localparam logic [7:0]  ContMask   = 8'h3F;

  // One encoded request: up to six bytes, lowest index goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } job_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

// ===== hw/rtl/u2u8_front.sv =====
// Front end: accepts code units, tracks a held high surrogate and builds
// a byte job for each unit. Depends on u2u8_pkg.
module u2u8_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     unit_i,
  input  logic            accept_i,
  output logic            push_o,
  output u2u8_pkg::job_t  job_o
);
  import u2u8_pkg::*;

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;

  // Plain 1..3 byte form of a single code unit, held or incoming.
  function automatic void enc_unit(input logic [15:0] u,
                                   output logic [2:0][7:0] b,
                                   output logic [1:0] n);
    b = '0;
    if ((u & Mask1Byte) == 16'h0000) begin
      b[0] = u[7:0];
      n    = 2'd1;
    end else if ((u & Mask2Byte) == 16'h0000) begin
      b[0] = Lead2 | {3'b000, u[10:6]};
      b[1] = ContByte | {2'b00, u[5:0]};
      n    = 2'd2;
    end else begin
      b[0] = Lead3 | {4'h0, u[15:12]};
      b[1] = ContByte | {2'b00, u[11:6]};
      b[2] = ContByte | {2'b00, u[5:0]};
      n    = 2'd3;
    end
  endfunction

  logic [2:0][7:0] held_b, unit_b;
  logic [1:0]      held_n, unit_n;
  logic            is_zero, is_high, is_low, flush, emit_unit;
  logic [4:0]      plane;
  logic [2:0]      base;

  always_comb begin
    enc_unit(HighSurr | {6'b000000, held_bits_q}, held_b, held_n);
    enc_unit(unit_i, unit_b, unit_n);
    is_zero = (unit_i == 16'h0000);
    is_high = ((unit_i & MaskSurr) == HighSurr);
    is_low  = ((unit_i & MaskSurr) == LowSurr);
    // cp[20:16] = high10[9:6] + 1
    plane   = {1'b0, held_bits_q[9:6]} + 5'd1;

    job_o        = '0;
    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    flush        = 1'b0;
    emit_unit    = 1'b0;

    priority if (is_zero) begin
      flush        = held_valid_q;
      held_valid_d = 1'b0;
      held_bits_d  = '0;
    end else if (held_valid_q && is_low) begin
      held_valid_d = 1'b0;
      held_bits_d  = '0;
    end else begin
      flush = held_valid_q;
      if (is_high) begin
        held_valid_d = 1'b1;
        held_bits_d  = unit_i[9:0];
      end else begin
        held_valid_d = 1'b0;
        held_bits_d  = '0;
        emit_unit    = 1'b1;
      end
    end

    base = flush ? {1'b0, held_n} : 3'd0;
    if (flush) begin
      job_o.bytes[0] = held_b[0];
      job_o.bytes[1] = held_b[1];
      job_o.bytes[2] = held_b[2];
    end

    if (!is_zero && held_valid_q && is_low) begin
      job_o.bytes[0] = Lead4 | {5'b00000, plane[4:2]};
      job_o.bytes[1] = ContByte | {2'b00, plane[1:0], held_bits_q[5:2]};
      job_o.bytes[2] = ContByte | {2'b00, held_bits_q[1:0], unit_i[9:6]};
      job_o.bytes[3] = ContByte | {2'b00, unit_i[5:0]};
      job_o.count    = 3'd4;
    end else if (is_zero) begin
      job_o.bytes[base] = 8'h00;
      job_o.count       = base + 3'd1;
    end else if (emit_unit) begin
      for (int i = 0; i < 3; i++) begin
        if (i < int'(unit_n)) begin
          job_o.bytes[base + 3'(i)] = unit_b[i];
        end
      end
      job_o.count = base + {1'b0, unit_n};
    end else begin
      job_o.count = base;
    end
  end

  assign push_o = accept_i && (job_o.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= '0;
    end else if (accept_i) begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

endmodule

// ===== hw/rtl/u2u8_jobq.sv =====
// Short job queue between front and back end.
// Depends on u2u8_pkg for the job type and depth.
module u2u8_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u2u8_pkg::job_t  job_i,
  input  logic            pop_i,
  output logic            full_o,
  output u2u8_pkg::head_t head_o
);
  import u2u8_pkg::*;

  localparam int unsigned PtrW = (JobQDepth > 1) ? $clog2(JobQDepth) : 1;
  localparam int unsigned CntW = $clog2(JobQDepth + 1);

  job_t            mem_q [JobQDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            empty;

  assign empty       = (cnt_q == '0);
  assign full_o      = (cnt_q == CntW'(JobQDepth));
  assign head_o.valid = !empty;
  assign head_o.job   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(JobQDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop_i) else $error("job queue underflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(JobQDepth)) else $error("job queue count out of range");
`endif

endmodule

// ===== hw/rtl/u2u8_back.sv =====
// Back end: walks the head job byte by byte into the output register.
// Depends on u2u8_pkg for the job and head types.
module u2u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u2u8_pkg::head_t head_i,
  output logic            pop_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [7:0]      m_tdata_o,
  output logic            m_tlast_o
);
  import u2u8_pkg::*;

  logic [CountW-1:0] idx_q;
  logic              load, at_end;
  logic              vld_q;
  logic [7:0]        data_q;
  logic              last_q;

  assign load   = head_i.valid && (!vld_q || m_tready_i);
  assign at_end = (idx_q == head_i.job.count - 1'b1);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= at_end ? '0 : idx_q + 1'b1;
      end else if (m_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= head_i.job.bytes[idx_q];
      last_q <= at_end;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

`ifndef NO_ASSERTIONS
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> (head_i.job.count != '0)) else $error("empty job queued");
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> (idx_q < head_i.job.count)) else $error("byte index past job");
  a_pop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (m_tvalid_o && m_tlast_o)) else $error("pop without last byte");
`endif

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder, top level.
// Depends on u2u8_pkg, u2u8_front, u2u8_jobq and u2u8_back.
//
// Usage:
//  - s_axis: one UTF-16 code unit per request (tdata[15:0] = code_unit).
//    A unit of zero ends the string: any held high surrogate is flushed
//    as three bytes, then a 00 terminator byte follows.
//  - m_axis: one UTF-8 byte per request (tdata[7:0] = out_byte); tlast
//    marks the final byte produced by one input unit.
//  - A high surrogate produces no bytes until the next unit arrives; a
//    following low surrogate yields the four-byte form, anything else
//    flushes the held unit as three bytes first.
// The first byte of a job passes through the job queue and then the output register.
// Throughput: one output byte per cycle while m_axis_tready is high, set
// by the single byte-wide output register of the back end; a unit
// produces from 0 to 6 bytes.
// The front end keeps accepting while the two-entry job queue has room,
// so it runs ahead of a stalled receiver; when m_axis_tready stays low
// the output byte holds and the queue fills, then s_axis_tready drops.
// Reset clears the held surrogate, the queue and the output valid.
module utf16_to_utf8_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);
  import u2u8_pkg::*;

  logic  push, pop, full, accept;
  job_t  job;
  head_t head;

  // Accept a unit whenever the queue can take its job.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  u2u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .unit_i   (s_axis_tdata),
    .accept_i (accept),
    .push_o   (push),
    .job_o    (job)
  );

  u2u8_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  u2u8_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
